[design/sixfk_pkg.sv]
// Shared types, constants and arithmetic helpers for the six-axis arm kinematics core.
package sixfk_pkg;

   // Q(FRAC_BITS) word as seen on the ports
   typedef logic signed [31:0] fix_type;

   // Multiplier operand (Q30 trig values, products, lengths) and raw product
   typedef logic signed [33:0] opnd_type;
   typedef logic signed [67:0] prod_type;

   // Wide accumulator for result sums ahead of saturation
   typedef logic signed [37:0] sum_type;

   // Reduced angle in Q32 radians for the CORDIC z path
   typedef logic signed [35:0] zang_type;

   typedef struct packed {
      fix_type base_angle;
      fix_type shoulder_angle;
      fix_type elbow_angle;
      fix_type wrist_one_angle;
      fix_type wrist_two_angle;
      fix_type wrist_three_angle;
   } fk_req_type;

   typedef struct packed {
      fix_type rot_xx;
      fix_type rot_xy;
      fix_type rot_xz;
      fix_type pos_x;
      fix_type rot_yx;
      fix_type rot_yy;
      fix_type rot_yz;
      fix_type pos_y;
      fix_type rot_zx;
      fix_type rot_zy;
      fix_type rot_zz;
      fix_type pos_z;
   } fk_rsp_type;

   // Register indexes of the write port
   typedef enum logic [2:0] {
      CSR_BASE_HEIGHT,
      CSR_UPPER_ARM_LENGTH,
      CSR_FOREARM_LENGTH,
      CSR_SHOULDER_OFFSET,
      CSR_WRIST_ONE_OFFSET,
      CSR_TOOL_FLANGE_OFFSET
   } csr_index_type;

   localparam int NUM_CSR = 6;

   localparam fix_type RST_BASE_HEIGHT        = 32'sd40775346;
   localparam fix_type RST_UPPER_ARM_LENGTH   = -32'sd65404299;
   localparam fix_type RST_FOREARM_LENGTH     = -32'sd57243861;
   localparam fix_type RST_SHOULDER_OFFSET    = 32'sd30158723;
   localparam fix_type RST_WRIST_ONE_OFFSET   = 32'sd22910966;
   localparam fix_type RST_TOOL_FLANGE_OFFSET = 32'sd21984864;

   // Trig lanes: joints 1, 2, 3, 5, 6 and the sum of joints 2..4
   localparam int NUM_LANES = 6;
   localparam int L_J1  = 0;
   localparam int L_J2  = 1;
   localparam int L_J3  = 2;
   localparam int L_J5  = 3;
   localparam int L_J6  = 4;
   localparam int L_J24 = 5;

   // Angle constants in Q32 radians
   localparam longint PI_Q32      = 64'sd13493037705;
   localparam longint TWO_PI_Q32  = 64'sd26986075409;
   localparam longint HALF_PI_Q32 = 64'sd6746518852;

   localparam zang_type PI_Z      = 36'sd13493037705;
   localparam zang_type TWO_PI_Z  = 36'sd26986075409;
   localparam zang_type HALF_PI_Z = 36'sd6746518852;

   // CORDIC start vector, gain folded in, Q30
   localparam opnd_type CORDIC_GAIN = 34'sd652032874;

   localparam zang_type ATAN_Q32 [32] = '{
      36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
      36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
      36'sd16777131,   36'sd8388597,    36'sd4194303,    36'sd2097152,
      36'sd1048576,    36'sd524288,     36'sd262144,     36'sd131072,
      36'sd65536,      36'sd32768,      36'sd16384,      36'sd8192,
      36'sd4096,       36'sd2048,       36'sd1024,       36'sd512,
      36'sd256,        36'sd128,        36'sd64,         36'sd32,
      36'sd16,         36'sd8,          36'sd4,          36'sd2
   };

   localparam prod_type PROD_HALF = 68'sd536870912;

   // Round a Q30 x Q30 product back to Q30, ties up
   function automatic opnd_type mq_round(prod_type p);
      prod_type t;
      t = p + PROD_HALF;
      return t[63:30];
   endfunction

   function automatic sum_type widen(opnd_type v);
      return sum_type'(v);
   endfunction

   // Clamp to the 32-bit signed range
   function automatic fix_type sat32(sum_type v);
      fix_type r;
      if (v > sum_type'(32'sh7fffffff)) begin
         r = 32'sh7fffffff;
      end else if (v < -sum_type'(64'sh80000000)) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[design/six_axis_arm_forward_kinematics_core.sv]
// Six-axis arm forward kinematics: range reduction, CORDIC and product pipeline.
// Depth: 14 + (31 - FRAC_BITS) + CORDIC_STAGES register stages from start to rsp_valid;
//   the CORDIC stage count dominates the depth at the default parameters.
// Throughput: one beat per cycle; busy stays low, every stage advances every cycle.
// Reset: synchronous, clears the valid pipeline and loads the nominal link lengths.
// The receiver cannot stall: each result is shown for exactly one cycle.
module six_axis_arm_forward_kinematics_core #(
   parameter int FRAC_BITS     = 28,
   parameter int CORDIC_STAGES = 28
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  sixfk_pkg::fk_req_type   req_data,
   output logic                    rsp_valid,
   output sixfk_pkg::fk_rsp_type   rsp_data,
   input  logic                    csr_write_en,
   input  sixfk_pkg::csr_index_type csr_index,
   input  sixfk_pkg::fix_type      csr_data
);
   import sixfk_pkg::*;

   localparam int SH  = 32 - FRAC_BITS;
   localparam int AW  = 66 - FRAC_BITS;
   localparam int QB  = 31 - FRAC_BITS;
   localparam int RS  = 30 - FRAC_BITS;
   localparam int ZW  = 36;
   localparam int LAT = 14 + QB + CORDIC_STAGES;
   localparam int N1  = 22;
   localparam int W1  = 18;
   localparam int N2  = 16;
   localparam int W2  = 14;
   localparam int N3  = 12;
   localparam logic signed [AW-1:0] TWO_PI_W = AW'(TWO_PI_Q32);
   localparam sum_type ROT_RND = sum_type'((1 << RS) >> 1);

   logic accept;
   logic [LAT-1:0] vld_ff;

   fix_type csr_ff [NUM_CSR];

   logic signed [AW-1:0] q_in  [NUM_LANES];
   logic signed [AW-1:0] ang_ff [NUM_LANES];
   logic signed [AW-1:0] rr_ff [QB+1][NUM_LANES];
   logic                 neg_ff [QB+1][NUM_LANES];
   zang_type             rt_c  [NUM_LANES];
   zang_type             r2_ff [NUM_LANES];
   logic                 ng2_ff [NUM_LANES];
   zang_type             z0_ff [NUM_LANES];
   opnd_type             cx_ff [CORDIC_STAGES+1][NUM_LANES];
   opnd_type             cy_ff [CORDIC_STAGES+1][NUM_LANES];
   zang_type             cz_ff [CORDIC_STAGES+1][NUM_LANES];
   logic                 fl_ff [CORDIC_STAGES+1][NUM_LANES];
   opnd_type             sn_ff [NUM_LANES];
   opnd_type             cs_ff [NUM_LANES];

   opnd_type m1a [N1];
   opnd_type m1b [N1];
   prod_type p1_ff [N1];
   opnd_type ks1_ff [NUM_LANES];
   opnd_type kc1_ff [NUM_LANES];
   opnd_type w1_ff [W1];
   opnd_type c23_ff;
   opnd_type s23_ff;
   opnd_type ks2_ff [NUM_LANES];
   opnd_type kc2_ff [NUM_LANES];

   opnd_type m2a [N2];
   opnd_type m2b [N2];
   prod_type p2_ff [N2];
   opnd_type x2_ff [W1];
   opnd_type s6m_ff;
   opnd_type c6m_ff;
   opnd_type w2_ff [W2];
   opnd_type p_ff;
   opnd_type qq_ff;
   opnd_type y2_ff [W1];
   opnd_type s6r_ff;
   opnd_type c6r_ff;

   opnd_type m3a [N3];
   opnd_type m3b [N3];
   prod_type p3_ff [N3];
   opnd_type x3_ff [W2];
   opnd_type y3_ff [W1];
   opnd_type w3_ff [N3];
   opnd_type x4_ff [W2];
   opnd_type y4_ff [W1];

   sum_type    rs_in [9];
   sum_type    rs_ff [9];
   sum_type    ph_in [6];
   sum_type    ph_ff [6];
   fix_type    rot_c [9];
   fk_rsp_type rsp_in;
   fk_rsp_type rsp_data_ff;

   // Handshake: always ready
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Advance the valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // Link length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff[CSR_BASE_HEIGHT]        <= RST_BASE_HEIGHT;
         csr_ff[CSR_UPPER_ARM_LENGTH]   <= RST_UPPER_ARM_LENGTH;
         csr_ff[CSR_FOREARM_LENGTH]     <= RST_FOREARM_LENGTH;
         csr_ff[CSR_SHOULDER_OFFSET]    <= RST_SHOULDER_OFFSET;
         csr_ff[CSR_WRIST_ONE_OFFSET]   <= RST_WRIST_ONE_OFFSET;
         csr_ff[CSR_TOOL_FLANGE_OFFSET] <= RST_TOOL_FLANGE_OFFSET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BASE_HEIGHT:        csr_ff[CSR_BASE_HEIGHT]        <= csr_data;
            CSR_UPPER_ARM_LENGTH:   csr_ff[CSR_UPPER_ARM_LENGTH]   <= csr_data;
            CSR_FOREARM_LENGTH:     csr_ff[CSR_FOREARM_LENGTH]     <= csr_data;
            CSR_SHOULDER_OFFSET:    csr_ff[CSR_SHOULDER_OFFSET]    <= csr_data;
            CSR_WRIST_ONE_OFFSET:   csr_ff[CSR_WRIST_ONE_OFFSET]   <= csr_data;
            CSR_TOOL_FLANGE_OFFSET: csr_ff[CSR_TOOL_FLANGE_OFFSET] <= csr_data;
            default: ;
         endcase
      end
   end

   // Scale joint angles to Q32 and form the joints 2..4 sum
   always_comb begin
      q_in[L_J1] = AW'($signed(req_data.base_angle)) <<< SH;
      q_in[L_J2] = AW'($signed(req_data.shoulder_angle)) <<< SH;
      q_in[L_J3] = AW'($signed(req_data.elbow_angle)) <<< SH;
      q_in[L_J5] = AW'($signed(req_data.wrist_two_angle)) <<< SH;
      q_in[L_J6] = AW'($signed(req_data.wrist_three_angle)) <<< SH;
      q_in[L_J24] = q_in[L_J2] + q_in[L_J3]
                  + (AW'($signed(req_data.wrist_one_angle)) <<< SH);
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         ang_ff[l]    <= q_in[l];
         neg_ff[0][l] <= ang_ff[l][AW-1];
         rr_ff[0][l]  <= ang_ff[l][AW-1] ? -ang_ff[l] : ang_ff[l];
      end
   end

   // Restoring reduction of the magnitude modulo two pi, one quotient bit a stage
   for (genvar t = 0; t < QB; t++) begin : g_red
      localparam logic signed [AW-1:0] SUBV = TWO_PI_W <<< (QB - 1 - t);
      always_ff @(posedge clock) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            neg_ff[t+1][l] <= neg_ff[t][l];
            rr_ff[t+1][l]  <= (rr_ff[t][l] >= SUBV) ? rr_ff[t][l] - SUBV : rr_ff[t][l];
         end
      end
   end

   // Fold into [-pi, pi], restore sign, then fold into [-pi/2, pi/2]
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         rt_c[l] = rr_ff[QB][l][ZW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         r2_ff[l]  <= (rt_c[l] > PI_Z) ? rt_c[l] - TWO_PI_Z : rt_c[l];
         ng2_ff[l] <= neg_ff[QB][l];
         z0_ff[l]  <= ng2_ff[l] ? -r2_ff[l] : r2_ff[l];
         cx_ff[0][l] <= CORDIC_GAIN;
         cy_ff[0][l] <= '0;
         if (z0_ff[l] > HALF_PI_Z) begin
            cz_ff[0][l] <= PI_Z - z0_ff[l];
            fl_ff[0][l] <= 1'b1;
         end else if (z0_ff[l] < -HALF_PI_Z) begin
            cz_ff[0][l] <= -PI_Z - z0_ff[l];
            fl_ff[0][l] <= 1'b1;
         end else begin
            cz_ff[0][l] <= z0_ff[l];
            fl_ff[0][l] <= 1'b0;
         end
      end
   end

   // CORDIC rotation, one micro-rotation a stage
   for (genvar st = 0; st < CORDIC_STAGES; st++) begin : g_cordic
      always_ff @(posedge clock) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            fl_ff[st+1][l] <= fl_ff[st][l];
            if (cz_ff[st][l] >= 0) begin
               cx_ff[st+1][l] <= cx_ff[st][l] - (cy_ff[st][l] >>> st);
               cy_ff[st+1][l] <= cy_ff[st][l] + (cx_ff[st][l] >>> st);
               cz_ff[st+1][l] <= cz_ff[st][l] - ATAN_Q32[st];
            end else begin
               cx_ff[st+1][l] <= cx_ff[st][l] + (cy_ff[st][l] >>> st);
               cy_ff[st+1][l] <= cy_ff[st][l] - (cx_ff[st][l] >>> st);
               cz_ff[st+1][l] <= cz_ff[st][l] + ATAN_Q32[st];
            end
         end
      end
   end

   // Apply the quadrant flip to the cosine
   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         sn_ff[l] <= cy_ff[CORDIC_STAGES][l];
         cs_ff[l] <= fl_ff[CORDIC_STAGES][l] ? -cx_ff[CORDIC_STAGES][l]
                                              : cx_ff[CORDIC_STAGES][l];
      end
   end

   // First product level: cc sc cs ss c5s1 c1c5 s1s5 c1s5 s4c5 s4s5 c1c2 s1c2
   // c4s6 c4c6 d5c4 a2s2 d4s1 d4c1, then c2c3 s2s3 s2c3 c2s3
   always_comb begin
      m1a[0]  = cs_ff[L_J1];  m1b[0]  = cs_ff[L_J24];
      m1a[1]  = sn_ff[L_J1];  m1b[1]  = cs_ff[L_J24];
      m1a[2]  = cs_ff[L_J1];  m1b[2]  = sn_ff[L_J24];
      m1a[3]  = sn_ff[L_J1];  m1b[3]  = sn_ff[L_J24];
      m1a[4]  = cs_ff[L_J5];  m1b[4]  = sn_ff[L_J1];
      m1a[5]  = cs_ff[L_J1];  m1b[5]  = cs_ff[L_J5];
      m1a[6]  = sn_ff[L_J1];  m1b[6]  = sn_ff[L_J5];
      m1a[7]  = cs_ff[L_J1];  m1b[7]  = sn_ff[L_J5];
      m1a[8]  = sn_ff[L_J24]; m1b[8]  = cs_ff[L_J5];
      m1a[9]  = sn_ff[L_J24]; m1b[9]  = sn_ff[L_J5];
      m1a[10] = cs_ff[L_J1];  m1b[10] = cs_ff[L_J2];
      m1a[11] = sn_ff[L_J1];  m1b[11] = cs_ff[L_J2];
      m1a[12] = cs_ff[L_J24]; m1b[12] = sn_ff[L_J6];
      m1a[13] = cs_ff[L_J24]; m1b[13] = cs_ff[L_J6];
      m1a[14] = opnd_type'(csr_ff[CSR_WRIST_ONE_OFFSET]);  m1b[14] = cs_ff[L_J24];
      m1a[15] = opnd_type'(csr_ff[CSR_UPPER_ARM_LENGTH]);  m1b[15] = sn_ff[L_J2];
      m1a[16] = opnd_type'(csr_ff[CSR_SHOULDER_OFFSET]);   m1b[16] = sn_ff[L_J1];
      m1a[17] = opnd_type'(csr_ff[CSR_SHOULDER_OFFSET]);   m1b[17] = cs_ff[L_J1];
      m1a[18] = cs_ff[L_J2];  m1b[18] = cs_ff[L_J3];
      m1a[19] = sn_ff[L_J2];  m1b[19] = sn_ff[L_J3];
      m1a[20] = sn_ff[L_J2];  m1b[20] = cs_ff[L_J3];
      m1a[21] = cs_ff[L_J2];  m1b[21] = sn_ff[L_J3];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N1; i++) begin
         p1_ff[i] <= m1a[i] * m1b[i];
      end
      for (int l = 0; l < NUM_LANES; l++) begin
         ks1_ff[l] <= sn_ff[l];
         kc1_ff[l] <= cs_ff[l];
         ks2_ff[l] <= ks1_ff[l];
         kc2_ff[l] <= kc1_ff[l];
      end
      for (int i = 0; i < W1; i++) begin
         w1_ff[i] <= mq_round(p1_ff[i]);
      end
      c23_ff <= mq_round(p1_ff[18]) - mq_round(p1_ff[19]);
      s23_ff <= mq_round(p1_ff[20]) + mq_round(p1_ff[21]);
   end

   // Second product level: u v d5cs d5ss d6c5s1 d6c1c5 a2c1c2 a2s1c2 d6s4s5
   // s4c5c6 s4c5s6 c1c23 s1c23 a3s23, then cc*c5 and sc*c5
   always_comb begin
      m2a[0]  = w1_ff[0];  m2b[0]  = ks2_ff[L_J5];
      m2a[1]  = w1_ff[1];  m2b[1]  = ks2_ff[L_J5];
      m2a[2]  = opnd_type'(csr_ff[CSR_WRIST_ONE_OFFSET]);   m2b[2]  = w1_ff[2];
      m2a[3]  = opnd_type'(csr_ff[CSR_WRIST_ONE_OFFSET]);   m2b[3]  = w1_ff[3];
      m2a[4]  = opnd_type'(csr_ff[CSR_TOOL_FLANGE_OFFSET]); m2b[4]  = w1_ff[4];
      m2a[5]  = opnd_type'(csr_ff[CSR_TOOL_FLANGE_OFFSET]); m2b[5]  = w1_ff[5];
      m2a[6]  = opnd_type'(csr_ff[CSR_UPPER_ARM_LENGTH]);   m2b[6]  = w1_ff[10];
      m2a[7]  = opnd_type'(csr_ff[CSR_UPPER_ARM_LENGTH]);   m2b[7]  = w1_ff[11];
      m2a[8]  = opnd_type'(csr_ff[CSR_TOOL_FLANGE_OFFSET]); m2b[8]  = w1_ff[9];
      m2a[9]  = w1_ff[8];  m2b[9]  = kc2_ff[L_J6];
      m2a[10] = w1_ff[8];  m2b[10] = ks2_ff[L_J6];
      m2a[11] = kc2_ff[L_J1]; m2b[11] = c23_ff;
      m2a[12] = ks2_ff[L_J1]; m2b[12] = c23_ff;
      m2a[13] = opnd_type'(csr_ff[CSR_FOREARM_LENGTH]);     m2b[13] = s23_ff;
      m2a[14] = w1_ff[0];  m2b[14] = kc2_ff[L_J5];
      m2a[15] = w1_ff[1];  m2b[15] = kc2_ff[L_J5];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N2; i++) begin
         p2_ff[i] <= m2a[i] * m2b[i];
      end
      for (int i = 0; i < W1; i++) begin
         x2_ff[i] <= w1_ff[i];
         y2_ff[i] <= x2_ff[i];
      end
      s6m_ff <= ks2_ff[L_J6];
      c6m_ff <= kc2_ff[L_J6];
      s6r_ff <= s6m_ff;
      c6r_ff <= c6m_ff;
      for (int i = 0; i < W2; i++) begin
         w2_ff[i] <= mq_round(p2_ff[i]);
      end
      p_ff  <= x2_ff[6] + mq_round(p2_ff[14]);
      qq_ff <= mq_round(p2_ff[15]) - x2_ff[7];
   end

   // Third product level: c6p s6cs c6cs s6p c6qq s6ss c6ss s6qq d6u d6v
   // a3c1c23 a3s1c23
   always_comb begin
      m3a[0]  = c6r_ff; m3b[0]  = p_ff;
      m3a[1]  = s6r_ff; m3b[1]  = y2_ff[2];
      m3a[2]  = c6r_ff; m3b[2]  = y2_ff[2];
      m3a[3]  = s6r_ff; m3b[3]  = p_ff;
      m3a[4]  = c6r_ff; m3b[4]  = qq_ff;
      m3a[5]  = s6r_ff; m3b[5]  = y2_ff[3];
      m3a[6]  = c6r_ff; m3b[6]  = y2_ff[3];
      m3a[7]  = s6r_ff; m3b[7]  = qq_ff;
      m3a[8]  = opnd_type'(csr_ff[CSR_TOOL_FLANGE_OFFSET]); m3b[8]  = w2_ff[0];
      m3a[9]  = opnd_type'(csr_ff[CSR_TOOL_FLANGE_OFFSET]); m3b[9]  = w2_ff[1];
      m3a[10] = opnd_type'(csr_ff[CSR_FOREARM_LENGTH]);     m3b[10] = w2_ff[11];
      m3a[11] = opnd_type'(csr_ff[CSR_FOREARM_LENGTH]);     m3b[11] = w2_ff[12];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N3; i++) begin
         p3_ff[i] <= m3a[i] * m3b[i];
         w3_ff[i] <= mq_round(p3_ff[i]);
      end
      for (int i = 0; i < W2; i++) begin
         x3_ff[i] <= w2_ff[i];
         x4_ff[i] <= x3_ff[i];
      end
      for (int i = 0; i < W1; i++) begin
         y3_ff[i] <= y2_ff[i];
         y4_ff[i] <= y3_ff[i];
      end
   end

   // Partial sums: rotation entries and two halves of each position
   always_comb begin
      rs_in[0] = widen(x4_ff[0]) - widen(y4_ff[4]);
      rs_in[1] = widen(w3_ff[0]) - widen(w3_ff[1]);
      rs_in[2] = -widen(w3_ff[2]) - widen(w3_ff[3]);
      rs_in[3] = widen(y4_ff[5]) + widen(x4_ff[1]);
      rs_in[4] = widen(w3_ff[4]) - widen(w3_ff[5]);
      rs_in[5] = -widen(w3_ff[6]) - widen(w3_ff[7]);
      rs_in[6] = -widen(y4_ff[9]);
      rs_in[7] = -widen(y4_ff[12]) - widen(x4_ff[9]);
      rs_in[8] = widen(x4_ff[10]) - widen(y4_ff[13]);
      ph_in[0] = -widen(x4_ff[2]) - widen(y4_ff[16]) + widen(w3_ff[8]);
      ph_in[1] = -widen(x4_ff[4]) - widen(x4_ff[6]) - widen(w3_ff[10]);
      ph_in[2] = -widen(x4_ff[3]) + widen(y4_ff[17]) + widen(w3_ff[9]);
      ph_in[3] = widen(x4_ff[5]) - widen(x4_ff[7]) - widen(w3_ff[11]);
      ph_in[4] = widen(opnd_type'(csr_ff[CSR_BASE_HEIGHT])) - widen(x4_ff[8])
               + widen(x4_ff[13]);
      ph_in[5] = widen(y4_ff[15]) - widen(y4_ff[14]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         rs_ff[i] <= rs_in[i];
      end
      for (int i = 0; i < 6; i++) begin
         ph_ff[i] <= ph_in[i];
      end
   end

   // Round rotation entries to the output format and saturate everything
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         rot_c[i] = sat32((rs_ff[i] + ROT_RND) >>> RS);
      end
      rsp_in.rot_xx = rot_c[0];
      rsp_in.rot_xy = rot_c[1];
      rsp_in.rot_xz = rot_c[2];
      rsp_in.pos_x  = sat32(ph_ff[0] + ph_ff[1]);
      rsp_in.rot_yx = rot_c[3];
      rsp_in.rot_yy = rot_c[4];
      rsp_in.rot_yz = rot_c[5];
      rsp_in.pos_y  = sat32(ph_ff[2] + ph_ff[3]);
      rsp_in.rot_zx = rot_c[6];
      rsp_in.rot_zy = rot_c[7];
      rsp_in.rot_zz = rot_c[8];
      rsp_in.pos_z  = sat32(ph_ff[4] + ph_ff[5]);
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = rsp_data_ff;

endmodule

[design/sixfk_checker.sv]
// Port-level checks for the kinematics core, attached by bind.
module sixfk_checker #(
   parameter int FRAC_BITS = 28,
   parameter int LAT       = 45
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input sixfk_pkg::fk_rsp_type    rsp_data
);
   import sixfk_pkg::*;

   // Rotation entries stay near unit magnitude
   localparam logic signed [32:0] RBND =
      33'((64'sd1 <<< FRAC_BITS) + (64'sd1 <<< (FRAC_BITS - 4)));

   // Every accepted beat yields a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_valid)
      else $error("accepted beat produced no result");

   // No result without a matching accepted beat
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without accepted beat");

   // The core never pushes back
   a_ready: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_rot_zx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed({rsp_data.rot_zx[31], rsp_data.rot_zx}) <= RBND)
                 && ($signed({rsp_data.rot_zx[31], rsp_data.rot_zx}) >= -RBND))
      else $error("rot_zx out of range");

endmodule

bind six_axis_arm_forward_kinematics_core sixfk_checker #(
   .FRAC_BITS(FRAC_BITS),
   .LAT(14 + 31 - FRAC_BITS + CORDIC_STAGES)
) u_sixfk_checker (.*);
